// ----- hw/rtl/aging_replacement_policy_unit_defines.svh -----
// Assertion macros used by the aging replacement policy controller
`ifndef AGING_REPLACEMENT_POLICY_UNIT_DEFINES_SVH
`define AGING_REPLACEMENT_POLICY_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ARP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/arp_pkg.sv -----
// Shared types and constants for the aging replacement policy unit
package arp_pkg;

  localparam int ENTRIES  = 16;
  localparam int AGE_BITS = 8;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic CMD_TOUCH  = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;

  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic       cmd;
    logic [3:0] entry_index;
    logic [3:0] partner_index;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_index;
    logic       victim_found;
    logic       swapped;
    logic [7:0] entry_age;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic touch;
    logic step;
    logic swap;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/arp_dp.sv -----
// Datapath: age/used store, victim scan registers and result register
module arp_dp
  import arp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  localparam age_t AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

  age_t               age [ENTRIES];
  logic [ENTRIES-1:0] used;

  idx_t ptr;
  logic item_cmd;
  logic entry_ok;
  idx_t p_ptr;
  logic p_ok;

  logic found;
  idx_t best_idx;
  age_t best_age;
  age_t p_age;
  logic p_used;

  age_t rd_age;
  logic rd_used;
  age_t touch_age;
  logic swap_ok;
  rsp_t rsp_next;

  // single read port, pointer set by the item or the scan counter
  assign rd_age    = age[ptr];
  assign rd_used   = used[ptr];
  assign touch_age = (rd_age >> 1) | AGE_TOP;
  assign swap_ok   = found && p_ok && (p_ptr != best_idx);

  assign stat.scan_last = (ptr == IDX_W'(ENTRIES - 1));

  always_comb begin
    rsp_next = '0;
    if (item_cmd == CMD_TOUCH) begin
      if (entry_ok) begin
        rsp_next.entry_age = 8'(touch_age);
      end
    end else if (found) begin
      rsp_next.victim_index = 4'(best_idx);
      rsp_next.victim_found = 1'b1;
      rsp_next.swapped      = swap_ok;
      rsp_next.entry_age    = 8'(best_age);
    end
  end

  // entry store; unused entries always hold age zero
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      ptr  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        ptr <= (req.cmd == CMD_VICTIM) ? '0 : IDX_W'(req.entry_index);
      end else if (cmd.step && !stat.scan_last) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.touch && entry_ok) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ptr == IDX_W'(i)) begin
            age[i]  <= touch_age;
            used[i] <= 1'b1;
          end else if (used[i]) begin
            age[i] <= age[i] >> 1;
          end
        end
      end
      if (cmd.swap && swap_ok) begin
        age[best_idx] <= p_used ? p_age : '0;
        age[p_ptr]    <= p_used ? best_age : '0;
      end
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd <= req.cmd;
      entry_ok <= (int'(req.entry_index) < ENTRIES);
      p_ptr    <= IDX_W'(req.partner_index);
      p_ok     <= (int'(req.partner_index) < ENTRIES);
      found    <= 1'b0;
      best_idx <= '0;
      best_age <= '0;
      p_age    <= '0;
      p_used   <= 1'b0;
    end else if (cmd.step) begin
      if (rd_used && (!found || rd_age < best_age)) begin
        found    <= 1'b1;
        best_idx <= ptr;
        best_age <= rd_age;
      end
      if (ptr == p_ptr) begin
        p_age  <= rd_age;
        p_used <= rd_used;
      end
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- hw/rtl/arp_ctrl.sv -----
// Controller: sequences touch, victim scan and swap, owns the result valid
`include "aging_replacement_policy_unit_defines.svh"

module arp_ctrl
  import arp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_cmd,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TOUCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_SWAP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_cmd == CMD_VICTIM) ? ST_SCAN : ST_TOUCH;
        end
      end
      ST_TOUCH: begin
        if (out_free) begin
          cmd.touch  = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        if (out_free) begin
          cmd.swap   = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ARP_ASSERT_NEXT(a_busy_after_accept, state == ST_IDLE && req_valid, state != ST_IDLE, "no busy after accept")
  `ARP_ASSERT_NOW(a_no_overwrite, cmd.finish, !(rsp_valid && rsp_stall), "result overwritten while stalled")
  `ARP_ASSERT_NEXT(a_scan_to_swap, state == ST_SCAN && stat.scan_last, state == ST_SWAP, "scan did not end in swap")
  `ARP_ASSERT_NEXT(a_finish_valid, cmd.finish, rsp_valid && state == ST_IDLE, "finish without result")

endmodule

// ----- hw/rtl/aging_replacement_policy_unit.sv -----
// Touch: accepted in idle, then the touch state updates the ages and registers the result.
// Victim: accepted in idle, scanned over the single entry read port, then swapped and registered.
// One beat at a time; the touch and swap states wait while the result output is stalled.
// Reset (rst, synchronous): all ages and used flags clear, controller idle, no result valid.
// Top level of the aging replacement policy unit
module aging_replacement_policy_unit
  import arp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  arp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  arp_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the aging replacement policy unit
module tb
  import arp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS = 930;

  // Tracks the per-entry ages and used flags and holds the responses still to come.
  class age_scoreboard;
    age_t ages[ENTRIES];
    bit   used[ENTRIES];
    rsp_t pending_rsp[$];
    int   mismatches;

    function new();
      foreach (ages[i]) begin
        ages[i] = '0;
        used[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void note_beat(req_t r);
      rsp_t exp_rsp;
      age_t tmp;
      int   best;
      bit   found;
      exp_rsp = '0;
      if (r.cmd == CMD_TOUCH) begin
        if (int'(r.entry_index) < ENTRIES) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && i != int'(r.entry_index)) ages[i] = ages[i] >> 1;
          end
          ages[r.entry_index] = (ages[r.entry_index] >> 1) | (age_t'(1) << (AGE_BITS - 1));
          used[r.entry_index] = 1'b1;
          exp_rsp.entry_age = 8'(ages[r.entry_index]);
        end
      end else begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (used[i] && (!found || ages[i] < ages[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          exp_rsp.victim_index = 4'(best);
          exp_rsp.victim_found = 1'b1;
          exp_rsp.entry_age = 8'(ages[best]);
          if (int'(r.partner_index) < ENTRIES && int'(r.partner_index) != best) begin
            tmp = ages[r.partner_index];
            ages[r.partner_index] = ages[best];
            ages[best] = tmp;
            exp_rsp.swapped = 1'b1;
          end
        end
      end
      // an unused entry never keeps an age, even after a swap into it
      for (int i = 0; i < ENTRIES; i++) begin
        if (!used[i]) ages[i] = '0;
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void check_beat(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display(
            "ERROR: response beat with nothing pending: idx=%0d found=%0b swp=%0b age=%02h",
            got.victim_index, got.victim_found, got.swapped, got.entry_age);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.victim_index !== exp_rsp.victim_index ||
          got.victim_found !== exp_rsp.victim_found ||
          got.swapped !== exp_rsp.swapped || got.entry_age !== exp_rsp.entry_age) begin
        mismatches++;
        if (mismatches <= 10)
          $display(
            "ERROR: exp idx=%0d fnd=%0b swp=%0b age=%02h got idx=%0d fnd=%0b swp=%0b age=%02h",
            exp_rsp.victim_index, exp_rsp.victim_found, exp_rsp.swapped, exp_rsp.entry_age,
            got.victim_index, got.victim_found, got.swapped, got.entry_age);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  age_scoreboard scb = new();

  aging_replacement_policy_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t make_req(logic cmd, int entry, int partner);
    req_t r;
    r.cmd = cmd;
    r.entry_index = 4'(entry);
    r.partner_index = 4'(partner);
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then maybe leave a gap.
  task automatic send_beat(req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    scb.note_beat(r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Mostly touches on a few hot entries so ages build up and ties appear.
  task automatic send_random(int count);
    req_t r;
    for (int n = 0; n < count; n++) begin
      r.cmd = ($urandom_range(99) < 30) ? CMD_VICTIM : CMD_TOUCH;
      r.entry_index = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
      r.partner_index = 4'($urandom_range(15));
      send_beat(r);
    end
  endtask

  // Receiver: checks response beats and drives the stall, with a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) scb.check_beat(rsp);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (hold_requests != hold_served) begin
        hold_served <= hold_served + 1;
        hold_left <= HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, ends of the index range, same / unused / used partner,
    // age saturating to all ones and others decaying to zero
    send_beat(make_req(CMD_VICTIM, 0, 3));
    send_beat(make_req(CMD_TOUCH, 0, 0));
    send_beat(make_req(CMD_TOUCH, 15, 15));
    send_beat(make_req(CMD_TOUCH, 0, 9));
    send_beat(make_req(CMD_VICTIM, 6, 15));
    send_beat(make_req(CMD_VICTIM, 0, 7));
    send_beat(make_req(CMD_VICTIM, 15, 0));
    send_beat(make_req(CMD_VICTIM, 0, 0));
    for (int i = 0; i < 8; i++) send_beat(make_req(CMD_TOUCH, 5, 10));
    send_beat(make_req(CMD_VICTIM, 15, 5));
    send_beat(make_req(CMD_TOUCH, 15, 15));
    send_beat(make_req(CMD_VICTIM, 15, 15));
    send_beat(make_req(CMD_TOUCH, 10, 5));
    send_beat(make_req(CMD_VICTIM, 0, 10));

    send_idle_pct <= 19;
    recv_stall_pct <= 67;
    send_random(RANDOM_BEATS / 3);

    send_idle_pct <= 67;
    recv_stall_pct <= 19;
    send_random(RANDOM_BEATS / 3);

    // no idling; open with a long receiver hold so the unit backs up
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    send_random(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
    req_valid <= 1'b0;

    while (scb.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (scb.mismatches == 0 && scb.pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d responses outstanding",
               scb.mismatches, scb.pending_rsp.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- aging_replacement_policy_unit.f -----
+incdir+hw/rtl
hw/rtl/arp_pkg.sv
hw/rtl/arp_dp.sv
hw/rtl/arp_ctrl.sv
hw/rtl/aging_replacement_policy_unit.sv
verif/tb.sv
